### hdl/bba_pkg.sv
// Shared types and codes for the buddy block allocator.
// Holds the tree node record, the node pair word kept in the mark memory,
// and the command and status codes. No dependencies.
package bba_pkg;

    // Width of the "lowest free level below" field of a node.
    localparam int AV_W = 5;
    localparam logic [AV_W-1:0] AV_NONE = 5'd31;

    // Fixed field widths of the stream words.
    localparam int ADR_W  = 64;
    localparam int SIZE_W = 17;
    localparam int CNT_W  = 11;
    localparam int LOW_W  = 16;

    // Commands carried in tuser of the input word.
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO     = 2'd1;
    localparam logic [1:0] ST_NOSPACE  = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    // One tree node. An unused node is all zero; avail is only meaningful
    // for a node that is in use but does not hold a block itself.
    typedef struct packed {
        logic            used;
        logic            holds;
        logic [AV_W-1:0] avail;
    } node_t;

    // Both children of one parent node, stored as one memory word.
    typedef struct packed {
        node_t left;
        node_t right;
    } pair_t;

    // Lowest level at which a grantable node exists in the subtree.
    function automatic logic [AV_W-1:0] node_avail(node_t n, logic [AV_W-1:0] lv);
        logic [AV_W-1:0] r;
        if (!n.used) begin
            r = lv;
        end else if (n.holds) begin
            r = AV_NONE;
        end else begin
            r = n.avail;
        end
        return r;
    endfunction

endpackage

### hdl/bba_mark_ram.sv
// Node mark memory of the buddy block allocator: one pair of child nodes
// per word, one write and one registered read port. Depends on bba_pkg.
module bba_mark_ram #(
    parameter int ADDR_W = 10
) (
    input  logic               aclk,
    input  logic               wr_en,
    input  logic [ADDR_W-1:0]  wr_addr,
    input  bba_pkg::pair_t     wr_data,
    input  logic [ADDR_W-1:0]  rd_addr,
    output bba_pkg::pair_t     rd_data
);
    import bba_pkg::*;

    pair_t mem [2**ADDR_W];

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

### hdl/buddy_block_allocator.sv
// Buddy block allocator: a request sequencer over the node mark memory.
// Depends on bba_pkg and bba_mark_ram.
//
// Usage: the input channel takes one word per request. tuser carries the
// command (allocate or free); tdata carries the request size and the
// address to free. Each request gives exactly one result word with a status
// in tuser and the granted or released block plus running totals in tdata.
// The heap base register is written through cfg_wr_en / cfg_wr_data and
// offsets the reported addresses and the addresses given to free.
// One request is worked at a time; the tree walk sets how long it takes.
// Each tree level costs one memory read going down (address set in the
// DOWN state, data taken in the READ state) and one memory write going
// up. A free whose block was the lowest live one walks the tree again to
// find the new lowest. After reset the mark memory is cleared word by
// word, during which s_tready stays low. A result waits in the output
// register while the receiver stalls; the next request is already taken
// and worked, and its result is held until the output register is free.
module buddy_block_allocator #(
    parameter int HEAP_LOG2      = 16,
    parameter int MIN_BLOCK_LOG2 = 6,
    parameter int TREE_LEVELS    = 10
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [63:0]  cfg_wr_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // request_size[16:0], free_address[80:17], zero fill above
    input  logic [87:0]  s_tdata,
    // command[0]
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // block_address[63:0], block_bytes[80:64], blocks_in_use[91:81],
    // bytes_in_use[108:92], lowest_address[172:109], any_in_use[173], zero fill
    output logic [175:0] m_tdata,
    // status[1:0]
    output logic [1:0]   m_tuser
);
    import bba_pkg::*;

    localparam int LV_W  = $clog2(TREE_LEVELS + 1);
    localparam int POS_W = TREE_LEVELS;
    localparam int OFF_W = HEAP_LOG2;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_CHECK = 4'd2;
    localparam logic [3:0] S_ADOWN = 4'd3;
    localparam logic [3:0] S_AREAD = 4'd4;
    localparam logic [3:0] S_FDOWN = 4'd5;
    localparam logic [3:0] S_FREAD = 4'd6;
    localparam logic [3:0] S_UP    = 4'd7;
    localparam logic [3:0] S_TOTAL = 4'd8;
    localparam logic [3:0] S_LDOWN = 4'd9;
    localparam logic [3:0] S_LREAD = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;

    // Offset within the heap of the node at position p of level l.
    function automatic logic [OFF_W-1:0] node_off(logic [POS_W-1:0] p, logic [LV_W-1:0] l);
        logic [63:0] w;
        w = 64'(p) << (HEAP_LOG2 - int'(l));
        return w[OFF_W-1:0];
    endfunction

    // Memory word holding the children of the node at position p of level l.
    function automatic logic [POS_W-1:0] node_idx(logic [LV_W-1:0] l, logic [POS_W-1:0] p);
        logic [POS_W:0] b;
        b = ((POS_W+1)'(1) << l) - (POS_W+1)'(1) + (POS_W+1)'(p);
        return b[POS_W-1:0];
    endfunction

    // Deepest level whose block still covers the request.
    function automatic logic [LV_W-1:0] level_for(logic [SIZE_W-1:0] need);
        logic [LV_W-1:0] cnt;
        cnt = '0;
        for (int l = 1; l <= TREE_LEVELS; l++) begin
            if ((HEAP_LOG2 - l >= SIZE_W) || (64'(need) <= (64'(1) << (HEAP_LOG2 - l)))) begin
                cnt = cnt + LV_W'(1);
            end
        end
        return cnt;
    endfunction

    logic [3:0]        state_reg;
    logic [POS_W-1:0]  clr_reg;
    logic [63:0]       base_reg;
    logic              cmd_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [63:0]       faddr_reg;
    logic [OFF_W-1:0]  off_reg;
    logic [LV_W-1:0]   lv_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [LV_W-1:0]   need_lv_reg;
    logic [LV_W-1:0]   blk_lv_reg;
    node_t             nd_reg;
    node_t             cur_reg;
    node_t             root_reg;
    node_t             sib_reg [0:TREE_LEVELS];
    logic [CNT_W-1:0]  live_reg;
    logic [SIZE_W-1:0] bytes_reg;
    logic [LOW_W-1:0]  lowest_reg;
    logic [SIZE_W-1:0] blk_bytes_reg;
    logic [1:0]        status_reg;
    logic              m_tvalid_reg;
    logic [175:0]      m_tdata_reg;
    logic [1:0]        m_tuser_reg;

    logic              ram_we;
    logic [POS_W-1:0]  ram_waddr;
    pair_t             ram_wdata;
    pair_t             ram_rdata;

    // Request decode.
    logic [SIZE_W-1:0] need;
    logic [63:0]       fdiff;
    logic [LV_W-1:0]   lv_inc;
    logic [LV_W-1:0]   lv_dec;
    node_t             up_sib;
    node_t             up_parent;
    logic [AV_W-1:0]   av_cur;
    logic [AV_W-1:0]   av_sib;
    logic [OFF_W-1:0]  off_shr;
    logic [63:0]       off64;
    logic [63:0]       cur_off64;
    logic [63:0]       blk_w;
    logic [SIZE_W-1:0] blk_bytes;
    logic [CNT_W-1:0]  live_dec;
    logic [63:0]       addr_out;
    logic [63:0]       low_out;

    assign need = (size_reg < SIZE_W'(64'(1) << MIN_BLOCK_LOG2)) ?
                  SIZE_W'(64'(1) << MIN_BLOCK_LOG2) : size_reg;
    assign fdiff     = faddr_reg - base_reg;
    assign lv_inc    = lv_reg + LV_W'(1);
    assign lv_dec    = lv_reg - LV_W'(1);
    assign off_shr   = off_reg >> (HEAP_LOG2 - 1 - int'(lv_reg));
    assign off64     = 64'(off_reg);
    assign cur_off64 = 64'(node_off(pos_reg, lv_reg));
    assign blk_w     = 64'(1) << (HEAP_LOG2 - int'(blk_lv_reg));
    assign blk_bytes = blk_w[SIZE_W-1:0];
    assign live_dec  = live_reg - CNT_W'(1);

    // Upward pass: merge the updated child with its saved sibling.
    assign up_sib = sib_reg[lv_reg];
    assign av_cur = node_avail(cur_reg, AV_W'(lv_reg));
    assign av_sib = node_avail(up_sib, AV_W'(lv_reg));
    always_comb begin
        if (!cur_reg.used && !up_sib.used) begin
            up_parent = '0;
        end else begin
            up_parent.used  = 1'b1;
            up_parent.holds = 1'b0;
            up_parent.avail = (av_cur < av_sib) ? av_cur : av_sib;
        end
    end

    // Memory write: clearing pass or one level of the upward pass.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = node_idx(lv_dec, pos_reg >> 1);
        ram_wdata = pos_reg[0] ? pair_t'{left: up_sib, right: cur_reg}
                               : pair_t'{left: cur_reg, right: up_sib};
        if (state_reg == S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            ram_wdata = '0;
        end else if (state_reg == S_UP && lv_reg != '0) begin
            ram_we = 1'b1;
        end
    end

    bba_mark_ram #(
        .ADDR_W (POS_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (node_idx(lv_reg, pos_reg)),
        .rd_data (ram_rdata)
    );

    // Result fields of the word being finished.
    assign addr_out = (status_reg != ST_OK) ? 64'd0 :
                      (cmd_reg == CMD_ALLOC) ? (base_reg + off64) : faddr_reg;
    assign low_out  = (live_reg != '0) ? (base_reg + 64'(lowest_reg)) : 64'd0;

    // Heap base register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= '0;
        end else if (cfg_wr_en) begin
            base_reg <= cfg_wr_data;
        end
    end

    // Request sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            root_reg     <= '0;
            live_reg     <= '0;
            bytes_reg    <= '0;
            lowest_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // The finishing state refills the output register itself.
            if (m_tvalid_reg && m_tready && state_reg != S_DONE) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + POS_W'(1);
                    if (clr_reg == '1) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_tvalid) begin
                        cmd_reg   <= s_tuser[0];
                        size_reg  <= s_tdata[16:0];
                        faddr_reg <= s_tdata[80:17];
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    lv_reg      <= '0;
                    pos_reg     <= '0;
                    nd_reg      <= root_reg;
                    need_lv_reg <= level_for(need);
                    state_reg   <= S_DONE;
                    if (cmd_reg == CMD_ALLOC) begin
                        if (size_reg == '0) begin
                            status_reg <= ST_ZERO;
                        end else if (64'(need) > (64'(1) << HEAP_LOG2)) begin
                            status_reg <= ST_NOSPACE;
                        end else if (node_avail(root_reg, '0) > AV_W'(level_for(need))) begin
                            status_reg <= ST_NOSPACE;
                        end else begin
                            state_reg <= S_ADOWN;
                        end
                    end else begin
                        off_reg <= fdiff[OFF_W-1:0];
                        if (faddr_reg < base_reg || (fdiff >> HEAP_LOG2) != 64'd0) begin
                            status_reg <= ST_NOTFOUND;
                        end else begin
                            state_reg <= S_FDOWN;
                        end
                    end
                end
                // Allocate: descend toward the leftmost grantable node.
                S_ADOWN: begin
                    if (lv_reg == need_lv_reg) begin
                        off_reg    <= node_off(pos_reg, lv_reg);
                        blk_lv_reg <= lv_reg;
                        cur_reg    <= '{used: 1'b1, holds: 1'b1, avail: AV_NONE};
                        state_reg  <= S_UP;
                    end else begin
                        state_reg <= S_AREAD;
                    end
                end
                S_AREAD: begin
                    if (node_avail(ram_rdata.left, AV_W'(lv_inc)) <= AV_W'(need_lv_reg)) begin
                        nd_reg          <= ram_rdata.left;
                        sib_reg[lv_inc] <= ram_rdata.right;
                        pos_reg         <= pos_reg << 1;
                    end else begin
                        nd_reg          <= ram_rdata.right;
                        sib_reg[lv_inc] <= ram_rdata.left;
                        pos_reg         <= (pos_reg << 1) | POS_W'(1);
                    end
                    lv_reg    <= lv_inc;
                    state_reg <= S_ADOWN;
                end
                // Free: follow the address down to the node that holds it.
                S_FDOWN: begin
                    if (nd_reg.holds) begin
                        if (node_off(pos_reg, lv_reg) == off_reg) begin
                            blk_lv_reg <= lv_reg;
                            cur_reg    <= '0;
                            state_reg  <= S_UP;
                        end else begin
                            status_reg <= ST_NOTFOUND;
                            state_reg  <= S_DONE;
                        end
                    end else if (!nd_reg.used || lv_reg == LV_W'(TREE_LEVELS)) begin
                        status_reg <= ST_NOTFOUND;
                        state_reg  <= S_DONE;
                    end else begin
                        state_reg <= S_FREAD;
                    end
                end
                S_FREAD: begin
                    nd_reg          <= off_shr[0] ? ram_rdata.right : ram_rdata.left;
                    sib_reg[lv_inc] <= off_shr[0] ? ram_rdata.left : ram_rdata.right;
                    pos_reg         <= (pos_reg << 1) | POS_W'(off_shr[0]);
                    lv_reg          <= lv_inc;
                    state_reg       <= S_FDOWN;
                end
                // Write the path back toward the root, one level a cycle.
                S_UP: begin
                    if (lv_reg == '0) begin
                        root_reg  <= cur_reg;
                        state_reg <= S_TOTAL;
                    end else begin
                        cur_reg <= up_parent;
                        lv_reg  <= lv_dec;
                        pos_reg <= pos_reg >> 1;
                    end
                end
                S_TOTAL: begin
                    blk_bytes_reg <= blk_bytes;
                    status_reg    <= ST_OK;
                    state_reg     <= S_DONE;
                    lv_reg        <= '0;
                    pos_reg       <= '0;
                    nd_reg        <= root_reg;
                    if (cmd_reg == CMD_ALLOC) begin
                        live_reg  <= live_reg + CNT_W'(1);
                        bytes_reg <= bytes_reg + blk_bytes;
                        if (live_reg == '0 || off64 < 64'(lowest_reg)) begin
                            lowest_reg <= off64[LOW_W-1:0];
                        end
                    end else begin
                        live_reg  <= live_dec;
                        bytes_reg <= bytes_reg - blk_bytes;
                        if (live_dec == '0) begin
                            lowest_reg <= '0;
                        end else if (off64 == 64'(lowest_reg)) begin
                            state_reg <= S_LDOWN;
                        end
                    end
                end
                // Find the new lowest live block: follow used children, left first.
                S_LDOWN: begin
                    if (nd_reg.holds) begin
                        lowest_reg <= cur_off64[LOW_W-1:0];
                        state_reg  <= S_DONE;
                    end else if (lv_reg == LV_W'(TREE_LEVELS)) begin
                        lowest_reg <= '0;
                        state_reg  <= S_DONE;
                    end else begin
                        state_reg <= S_LREAD;
                    end
                end
                S_LREAD: begin
                    nd_reg    <= ram_rdata.left.used ? ram_rdata.left : ram_rdata.right;
                    pos_reg   <= (pos_reg << 1) | POS_W'(!ram_rdata.left.used);
                    lv_reg    <= lv_inc;
                    state_reg <= S_LDOWN;
                end
                // Hand the result word to the output register once it is free.
                S_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= status_reg;
                        m_tdata_reg  <= {2'b00,
                                         (live_reg != '0),
                                         low_out,
                                         bytes_reg,
                                         live_reg,
                                         (status_reg == ST_OK) ? blk_bytes_reg : SIZE_W'(0),
                                         addr_out};
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // A failed request reports no block.
    a_fail_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ST_OK |-> m_tdata[80:0] == '0)
        else $error("failed request reports a block");

    // The in-use flag agrees with the block count.
    a_any_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[173] == (m_tdata[91:81] != '0))
        else $error("in-use flag disagrees with block count");

    // An unused root means nothing is live.
    a_root_live: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_IDLE && !root_reg.used |-> live_reg == '0)
        else $error("live blocks with an empty tree");

endmodule
